### src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/car_pkg.sv
// Types and constants of the common average reference filter.
package car_pkg;

  localparam int IN_CH_W   = 7;
  localparam int IDX_W     = 4;
  localparam int SAMPLE_W  = 24;
  localparam int OUT_W     = 25;
  localparam int TARGET_W  = 6;
  localparam int COUNT_W   = 7;
  localparam int REG_W     = 64;
  localparam int REG_IDX_W = 3;

  localparam int OUT_MAX = 16777215;
  localparam int OUT_MIN = -16777216;

  localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUT_EN = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CAR_EN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MASK   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COUNT  = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SUM,
    S_PREP,
    S_DIV,
    S_FIN,
    S_DONE
  } car_state_t;

endpackage

### src/car_in_if.sv
// Input request channel: one tagged sample.
interface car_in_if;
  import car_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [IN_CH_W-1:0]         channel;
  logic [IDX_W-1:0]           sample_index;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, channel, sample_index, sample_value, input ready);
  modport sink (input valid, channel, sample_index, sample_value, output ready);
endinterface

### src/car_out_if.sv
// Output request channel: one filtered sample.
interface car_out_if;
  import car_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_index;
  logic signed [OUT_W-1:0] filtered_value;

  modport source (output valid, out_index, filtered_value, input ready);
  modport sink (input valid, out_index, filtered_value, output ready);
endinterface

### src/common_average_reference_filter.sv
// Common average reference filter: stores samples by channel and index, emits referenced target.
// The referenced path walks the store over one read port, then runs a bit-serial divide;
// the raw pass (CAR disabled) emits the target sample as it came in, skipping both.
// One request is in work at a time; the output register frees the input side early.
// Reset restores the registers to their defaults, then a clear pass zeroes the whole
// store; no request is taken during that pass, configuration writes are.
module common_average_reference_filter #(
  parameter int CHANNELS     = 64,
  parameter int BLOCK_LENGTH = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [car_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [car_pkg::REG_W-1:0]       cfg_data,
  car_in_if.sink                          in_ch,
  car_out_if.source                       out_ch
);
  import car_pkg::*;

  localparam int DEPTH = CHANNELS * BLOCK_LENGTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CH_W  = $clog2(CHANNELS);
  localparam int SUM_W = SAMPLE_W + CH_W;
  localparam int DW    = SUM_W + 2;
  localparam int DCW   = $clog2(SUM_W);
  localparam int WA_W  = 11;

  car_state_t state, state_next;

  logic [TARGET_W-1:0] target;
  logic                out_en;
  logic                car_en;
  logic [CHANNELS-1:0] mask;
  logic [COUNT_W-1:0]  count;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              clr_addr;
  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic signed [SAMPLE_W-1:0] mem_wd;
  logic [WA_W-1:0]            wa_full;

  logic [IDX_W-1:0]           idx;
  logic signed [SAMPLE_W-1:0] val;
  logic [CH_W:0]              cnt;
  logic                       rd_pend;
  logic                       rd_inc;
  logic signed [SUM_W-1:0]    acc;
  logic                       neg;
  logic [SUM_W-1:0]           quo;
  logic [COUNT_W-1:0]         rem;
  logic [COUNT_W-1:0]         divisor;
  logic [DCW-1:0]             div_cnt;
  logic [COUNT_W:0]           div_sh;
  logic                       div_ge;
  logic signed [SUM_W:0]      avg;
  logic signed [DW-1:0]       diff;
  logic signed [OUT_W-1:0]    res;
  logic signed [OUT_W-1:0]    res_sat;

  logic                    out_valid;
  logic [IDX_W-1:0]        out_idx;
  logic signed [OUT_W-1:0] out_val;

  logic accept;
  logic idx_ok;
  logic hit;
  logic in_ready;
  logic out_load;
  logic sum_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
      out_en <= 1'b0;
      car_en <= 1'b0;
      mask   <= '1;
      count  <= COUNT_W'(64);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TARGET: target <= cfg_data[TARGET_W-1:0];
        REG_OUT_EN: out_en <= cfg_data[0];
        REG_CAR_EN: car_en <= cfg_data[0];
        REG_MASK:   mask   <= cfg_data[CHANNELS-1:0];
        REG_COUNT:  count  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept   = in_ch.valid && in_ready;
  assign idx_ok   = in_ch.sample_index < IDX_W'(BLOCK_LENGTH);
  assign hit      = idx_ok && out_en && (in_ch.channel == {1'b0, target});
  assign sum_last = cnt == (CH_W + 1)'(CHANNELS);
  assign wa_full  = WA_W'(in_ch.channel) * WA_W'(BLOCK_LENGTH) + WA_W'(in_ch.sample_index);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept && hit) state_next = car_en ? S_SUM : S_DONE;
      end
      S_SUM: begin
        if (sum_last) state_next = S_PREP;
      end
      S_PREP: begin
        state_next = (count <= COUNT_W'(1)) ? S_FIN : S_DIV;
      end
      S_DIV: begin
        if (div_cnt == DCW'(SUM_W - 1)) state_next = S_FIN;
      end
      S_FIN: state_next = S_DONE;
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = clr_addr;
    mem_wd   = '0;
    out_load = 1'b0;
    unique case (state)
      S_CLEAR: mem_we = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        mem_we   = in_ch.valid && idx_ok && (in_ch.channel < IN_CH_W'(CHANNELS));
        mem_wa   = wa_full[AW-1:0];
        mem_wd   = in_ch.sample_value;
      end
      S_DONE: out_load = !out_valid || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign div_sh  = {rem, quo[SUM_W-1]};
  assign div_ge  = div_sh >= {1'b0, divisor};
  assign avg     = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign diff    = DW'(val) - DW'(avg);

  always_comb begin
    if (diff > DW'(OUT_MAX)) begin
      res_sat = OUT_W'(OUT_MAX);
    end else if (diff < DW'(OUT_MIN)) begin
      res_sat = OUT_W'(OUT_MIN);
    end else begin
      res_sat = diff[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          if (accept) begin
            idx     <= in_ch.sample_index;
            val     <= in_ch.sample_value;
            res     <= OUT_W'(in_ch.sample_value);
            rd_addr <= AW'(in_ch.sample_index);
            cnt     <= '0;
            acc     <= '0;
          end
        end
        S_SUM: begin
          if (!sum_last) begin
            rd_addr <= rd_addr + AW'(BLOCK_LENGTH);
            rd_inc  <= mask[cnt[CH_W-1:0]] && (IN_CH_W'(cnt) != {1'b0, target});
            rd_pend <= 1'b1;
            cnt     <= cnt + (CH_W + 1)'(1);
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && rd_inc) begin
            acc <= acc + SUM_W'(rd_data);
          end
        end
        S_PREP: begin
          neg     <= acc[SUM_W-1];
          quo     <= (count <= COUNT_W'(1)) ? '0 : (acc[SUM_W-1] ? -acc : acc);
          rem     <= '0;
          divisor <= count - COUNT_W'(1);
          div_cnt <= '0;
        end
        S_DIV: begin
          rem     <= div_ge ? COUNT_W'(div_sh - {1'b0, divisor}) : div_sh[COUNT_W-1:0];
          quo     <= {quo[SUM_W-2:0], div_ge};
          div_cnt <= div_cnt + DCW'(1);
        end
        S_FIN: res <= res_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx <= idx;
      out_val <= res;
    end
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.out_index      = out_idx;
  assign out_ch.filtered_value = out_val;

`include "assert_macros.svh"

  `ASSERT_SAME(a_no_write_in_walk, state == S_SUM || state == S_DIV, !mem_we, "store written during walk")
  `ASSERT_NEXT(a_clear_holds, state == S_CLEAR && clr_addr != AW'(DEPTH - 1), state == S_CLEAR, "clear pass ended early")
  `ASSERT_NEXT(a_done_emits, out_load, out_ch.valid && state == S_IDLE, "result not presented")

endmodule
